FILE: rtl/core/mtsq_pkg.sv
// Shared constants, widths and types for the transform decomposition pipeline.
package mtsq_pkg;

    localparam int Q_ONE     = 65536;
    localparam int Q_FRAC    = 16;
    localparam int DATA_W    = 32;
    localparam int SCALE_W   = 31;

    // row length: sum of squares and its root
    localparam int SC_IN_W   = 64;
    localparam int SC_RT_W   = SC_IN_W / 2;

    // quaternion root: clamped argument shifted by the fraction width
    localparam int ARG_W     = 34;
    localparam int QS_IN_W   = ARG_W + Q_FRAC;
    localparam int QS_RT_W   = QS_IN_W / 2;
    localparam int HALF_W    = QS_RT_W - 1;

    // divide: numerator magnitude shifted by the fraction width over S = 2r
    localparam int MAG_W     = DATA_W + 1;
    localparam int NUM_W     = MAG_W + Q_FRAC;
    localparam int DEN_W     = QS_RT_W + 1;

    // pipeline alignment, counted from the first register stage
    localparam int MAG_DLY   = QS_RT_W;
    localparam int HALF_DLY  = NUM_W;
    localparam int SIDE_DLY  = QS_RT_W + NUM_W;
    localparam int SC_DLY    = SIDE_DLY - 1 - SC_RT_W;
    localparam int PIPE_LAT  = SIDE_DLY + 2;

    typedef enum logic [1:0] {
        BR_W = 2'd0,
        BR_X = 2'd1,
        BR_Y = 2'd2,
        BR_Z = 2'd3
    } t_branch;

endpackage

FILE: rtl/core/mtsq_delay.sv
// Enable-gated shift register that keeps side data aligned with the pipeline.
module mtsq_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);
    logic [WIDTH-1:0] r_tap [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_d;
            for (int k = 1; k < DEPTH; k++) begin
                r_tap[k] <= r_tap[k-1];
            end
        end
    end

    assign o_q = r_tap[DEPTH-1];
endmodule

FILE: rtl/core/mtsq_sqrt.sv
// Pipelined floor integer square root, one root bit per register stage.
module mtsq_sqrt #(
    parameter int IN_W  = 64,
    parameter int OUT_W = IN_W / 2
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [IN_W-1:0]  i_val,
    output logic [OUT_W-1:0] o_root
);
    localparam int REM_W = OUT_W + 2;

    logic [IN_W-1:0]  r_val  [OUT_W];
    logic [REM_W-1:0] r_rem  [OUT_W];
    logic [OUT_W-1:0] r_root [OUT_W];
    logic [IN_W-1:0]  n_val  [OUT_W];
    logic [REM_W-1:0] n_rem  [OUT_W];
    logic [OUT_W-1:0] n_root [OUT_W];

    always_comb begin
        logic [IN_W-1:0]  v_in;
        logic [REM_W-1:0] rem_in;
        logic [OUT_W-1:0] root_in;
        logic [REM_W-1:0] t_rem;
        logic [REM_W-1:0] trial;
        for (int k = 0; k < OUT_W; k++) begin
            if (k == 0) begin
                v_in    = i_val;
                rem_in  = '0;
                root_in = '0;
            end else begin
                v_in    = r_val[k-1];
                rem_in  = r_rem[k-1];
                root_in = r_root[k-1];
            end
            t_rem = {rem_in[REM_W-3:0], v_in[IN_W-1 -: 2]};
            trial = {root_in, 2'b01};
            n_val[k] = {v_in[IN_W-3:0], 2'b00};
            if (t_rem >= trial) begin
                n_rem[k]  = t_rem - trial;
                n_root[k] = {root_in[OUT_W-2:0], 1'b1};
            end else begin
                n_rem[k]  = t_rem;
                n_root[k] = {root_in[OUT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < OUT_W; k++) begin
                r_val[k]  <= n_val[k];
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
            end
        end
    end

    assign o_root = r_root[OUT_W-1];
endmodule

FILE: rtl/core/mtsq_div.sv
// Pipelined restoring unsigned divider, one quotient bit per register stage.
module mtsq_div #(
    parameter int NUM_W = 49,
    parameter int DEN_W = 26
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quo
);
    logic [NUM_W-1:0] r_num [NUM_W];
    logic [DEN_W-1:0] r_den [NUM_W];
    logic [DEN_W-1:0] r_rem [NUM_W];
    logic [NUM_W-1:0] r_quo [NUM_W];
    logic [NUM_W-1:0] n_num [NUM_W];
    logic [DEN_W-1:0] n_den [NUM_W];
    logic [DEN_W-1:0] n_rem [NUM_W];
    logic [NUM_W-1:0] n_quo [NUM_W];

    always_comb begin
        logic [NUM_W-1:0] num_in;
        logic [DEN_W-1:0] den_in;
        logic [DEN_W-1:0] rem_in;
        logic [NUM_W-1:0] quo_in;
        logic [DEN_W:0]   t_rem;
        logic [DEN_W:0]   diff;
        for (int k = 0; k < NUM_W; k++) begin
            if (k == 0) begin
                num_in = i_num;
                den_in = i_den;
                rem_in = '0;
                quo_in = '0;
            end else begin
                num_in = r_num[k-1];
                den_in = r_den[k-1];
                rem_in = r_rem[k-1];
                quo_in = r_quo[k-1];
            end
            t_rem    = {rem_in, num_in[NUM_W-1]};
            diff     = t_rem - {1'b0, den_in};
            n_num[k] = {num_in[NUM_W-2:0], 1'b0};
            n_den[k] = den_in;
            if (t_rem >= {1'b0, den_in}) begin
                n_rem[k] = diff[DEN_W-1:0];
                n_quo[k] = {quo_in[NUM_W-2:0], 1'b1};
            end else begin
                n_rem[k] = t_rem[DEN_W-1:0];
                n_quo[k] = {quo_in[NUM_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < NUM_W; k++) begin
                r_num[k] <= n_num[k];
                r_den[k] <= n_den[k];
                r_rem[k] <= n_rem[k];
                r_quo[k] <= n_quo[k];
            end
        end
    end

    assign o_quo = r_quo[NUM_W-1];
endmodule

FILE: rtl/core/matrix_to_scale_quat_pos.sv
// Top level: splits a 3x4 transform into row scales, quaternion and position.
//
// Input channel: i_valid / o_ready, with the twelve Q16.16 matrix entries.
// Output channel: o_valid / i_ready, with three scales, the quaternion and the
// position. One result item for every accepted input item, in order.
// The item passes 76 register stages, the first loaded at the accepting edge: one
// stage for products, trace and branch select, 25 stages of the quaternion root
// (one root bit each), 49 stages of the divider (one quotient bit each) and one
// output register. The row lengths run through a 32-stage root in parallel and
// are delayed to line up.
// Throughput is one item per cycle unless the receiver stalls; the whole pipeline advances together.
// When the receiver holds i_ready low while o_valid is high, every stage
// freezes and o_ready drops, so nothing is lost or repeated.
// Reset clears all valid bits; the datapath registers are not reset.
module matrix_to_scale_quat_pos (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [mtsq_pkg::DATA_W-1:0] i_xaxis_x,
    input  logic signed [mtsq_pkg::DATA_W-1:0] i_xaxis_y,
    input  logic signed [mtsq_pkg::DATA_W-1:0] i_xaxis_z,
    input  logic signed [mtsq_pkg::DATA_W-1:0] i_yaxis_x,
    input  logic signed [mtsq_pkg::DATA_W-1:0] i_yaxis_y,
    input  logic signed [mtsq_pkg::DATA_W-1:0] i_yaxis_z,
    input  logic signed [mtsq_pkg::DATA_W-1:0] i_zaxis_x,
    input  logic signed [mtsq_pkg::DATA_W-1:0] i_zaxis_y,
    input  logic signed [mtsq_pkg::DATA_W-1:0] i_zaxis_z,
    input  logic signed [mtsq_pkg::DATA_W-1:0] i_trans_x,
    input  logic signed [mtsq_pkg::DATA_W-1:0] i_trans_y,
    input  logic signed [mtsq_pkg::DATA_W-1:0] i_trans_z,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [mtsq_pkg::SCALE_W-1:0]  o_scale_x,
    output logic [mtsq_pkg::SCALE_W-1:0]  o_scale_y,
    output logic [mtsq_pkg::SCALE_W-1:0]  o_scale_z,
    output logic signed [mtsq_pkg::DATA_W-1:0] o_quat_w,
    output logic signed [mtsq_pkg::DATA_W-1:0] o_quat_x,
    output logic signed [mtsq_pkg::DATA_W-1:0] o_quat_y,
    output logic signed [mtsq_pkg::DATA_W-1:0] o_quat_z,
    output logic signed [mtsq_pkg::DATA_W-1:0] o_pos_x,
    output logic signed [mtsq_pkg::DATA_W-1:0] o_pos_y,
    output logic signed [mtsq_pkg::DATA_W-1:0] o_pos_z
);
    import mtsq_pkg::*;

    localparam int SIDE_W = 3 * DATA_W + 2 + 3;

    logic                  adv;
    logic [PIPE_LAT-1:0]   r_vld;

    // stage 1
    logic [SC_IN_W-2:0]    r_sq [9];
    logic [ARG_W-1:0]      r_arg;
    t_branch               r_br;
    logic [MAG_W-1:0]      r_mag [3];
    logic [2:0]            r_neg;
    logic [3*DATA_W-1:0]   r_pos;
    logic [SC_IN_W-2:0]    n_sq [9];
    logic [ARG_W-1:0]      n_arg;
    t_branch               n_br;
    logic [MAG_W-1:0]      n_mag [3];
    logic [2:0]            n_neg;

    // stage 2
    logic [SC_IN_W-1:0]    r_ssum [3];

    logic [SC_RT_W-1:0]    sc_root [3];
    logic [SC_RT_W-1:0]    sc_dly  [3];
    logic [QS_RT_W-1:0]    q_root;
    logic [3*MAG_W-1:0]    mag_dly;
    logic [NUM_W-1:0]      quo [3];
    logic [HALF_W:0]       half_dly;
    logic [SIDE_W-1:0]     side_dly;

    logic [2:0]            e_neg;
    t_branch               e_br;
    logic [3*DATA_W-1:0]   e_pos;
    logic [HALF_W-1:0]     e_half;
    logic                  e_szero;
    logic [DATA_W-1:0]     e_slot [3];
    logic [DATA_W-1:0]     n_quat [4];
    logic [SCALE_W-1:0]    n_scale [3];

    assign adv     = ~o_valid | i_ready;
    assign o_ready = adv;
    assign o_valid = r_vld[PIPE_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], i_valid};
        end
    end

    // stage 1: squares, trace, branch, root argument, numerators
    always_comb begin
        logic signed [DATA_W-1:0]   m [9];
        logic signed [SC_IN_W-1:0]  p;
        logic signed [DATA_W+1:0]   tr;
        logic signed [ARG_W:0]      arg;
        logic signed [DATA_W:0]     d21_12, d02_20, d10_01, s01_10, s02_20, s12_21;
        logic signed [DATA_W:0]     num [3];
        m[0] = i_xaxis_x; m[1] = i_xaxis_y; m[2] = i_xaxis_z;
        m[3] = i_yaxis_x; m[4] = i_yaxis_y; m[5] = i_yaxis_z;
        m[6] = i_zaxis_x; m[7] = i_zaxis_y; m[8] = i_zaxis_z;
        for (int k = 0; k < 9; k++) begin
            p        = m[k] * m[k];
            n_sq[k]  = p[SC_IN_W-2:0];
        end
        tr = (DATA_W+2)'(m[0]) + (DATA_W+2)'(m[4]) + (DATA_W+2)'(m[8]);
        d21_12 = (DATA_W+1)'(m[7]) - (DATA_W+1)'(m[5]);
        d02_20 = (DATA_W+1)'(m[2]) - (DATA_W+1)'(m[6]);
        d10_01 = (DATA_W+1)'(m[3]) - (DATA_W+1)'(m[1]);
        s01_10 = (DATA_W+1)'(m[1]) + (DATA_W+1)'(m[3]);
        s02_20 = (DATA_W+1)'(m[2]) + (DATA_W+1)'(m[6]);
        s12_21 = (DATA_W+1)'(m[5]) + (DATA_W+1)'(m[7]);
        if (tr > 0) begin
            n_br = BR_W;
        end else if (m[0] > m[4] && m[0] > m[8]) begin
            n_br = BR_X;
        end else if (m[4] > m[8]) begin
            n_br = BR_Y;
        end else begin
            n_br = BR_Z;
        end
        // numerators listed in component order, skipping the branch's own
        case (n_br)
            BR_W: begin
                arg = (ARG_W+1)'(tr) + (ARG_W+1)'(Q_ONE);
                num[0] = d21_12; num[1] = d02_20; num[2] = d10_01;
            end
            BR_X: begin
                arg = (ARG_W+1)'(Q_ONE) + (ARG_W+1)'(m[0])
                    - (ARG_W+1)'(m[4]) - (ARG_W+1)'(m[8]);
                num[0] = d21_12; num[1] = s01_10; num[2] = s02_20;
            end
            BR_Y: begin
                arg = (ARG_W+1)'(Q_ONE) + (ARG_W+1)'(m[4])
                    - (ARG_W+1)'(m[0]) - (ARG_W+1)'(m[8]);
                num[0] = d02_20; num[1] = s01_10; num[2] = s12_21;
            end
            default: begin
                arg = (ARG_W+1)'(Q_ONE) + (ARG_W+1)'(m[8])
                    - (ARG_W+1)'(m[0]) - (ARG_W+1)'(m[4]);
                num[0] = d10_01; num[1] = s02_20; num[2] = s12_21;
            end
        endcase
        n_arg = arg[ARG_W] ? '0 : arg[ARG_W-1:0];
        for (int k = 0; k < 3; k++) begin
            n_neg[k] = num[k][DATA_W];
            n_mag[k] = num[k][DATA_W] ? MAG_W'(-num[k]) : MAG_W'(num[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 9; k++) begin
                r_sq[k] <= n_sq[k];
            end
            for (int k = 0; k < 3; k++) begin
                r_mag[k] <= n_mag[k];
            end
            r_arg <= n_arg;
            r_br  <= n_br;
            r_neg <= n_neg;
            r_pos <= {i_trans_z, i_trans_y, i_trans_x};
        end
    end

    // stage 2: sums of squares
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                r_ssum[k] <= SC_IN_W'(r_sq[3*k]) + SC_IN_W'(r_sq[3*k+1])
                           + SC_IN_W'(r_sq[3*k+2]);
            end
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_scale
        mtsq_sqrt #(.IN_W(SC_IN_W), .OUT_W(SC_RT_W)) u_sqrt (
            .i_clk  (i_clk),
            .i_en   (adv),
            .i_val  (r_ssum[g]),
            .o_root (sc_root[g])
        );
        mtsq_delay #(.WIDTH(SC_RT_W), .DEPTH(SC_DLY)) u_dly (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_d   (sc_root[g]),
            .o_q   (sc_dly[g])
        );
    end

    mtsq_sqrt #(.IN_W(QS_IN_W), .OUT_W(QS_RT_W)) u_qsqrt (
        .i_clk  (i_clk),
        .i_en   (adv),
        .i_val  ({r_arg, {Q_FRAC{1'b0}}}),
        .o_root (q_root)
    );

    mtsq_delay #(.WIDTH(3*MAG_W), .DEPTH(MAG_DLY)) u_mag_dly (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_d   ({r_mag[2], r_mag[1], r_mag[0]}),
        .o_q   (mag_dly)
    );

    for (genvar g = 0; g < 3; g++) begin : g_div
        mtsq_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_num ({mag_dly[g*MAG_W +: MAG_W], {Q_FRAC{1'b0}}}),
            .i_den ({q_root, 1'b0}),
            .o_quo (quo[g])
        );
    end

    mtsq_delay #(.WIDTH(HALF_W+1), .DEPTH(HALF_DLY)) u_half_dly (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_d   ({q_root == '0, q_root[QS_RT_W-1:1]}),
        .o_q   (half_dly)
    );

    mtsq_delay #(.WIDTH(SIDE_W), .DEPTH(SIDE_DLY)) u_side_dly (
        .i_clk (i_clk),
        .i_en  (adv),
        .i_d   ({r_pos, r_br, r_neg}),
        .o_q   (side_dly)
    );

    // final stage: sign, saturation and slot-to-component mapping
    always_comb begin
        logic over;
        over    = 1'b0;
        e_neg   = side_dly[2:0];
        e_br    = t_branch'(side_dly[4:3]);
        e_pos   = side_dly[SIDE_W-1:5];
        e_half  = half_dly[HALF_W-1:0];
        e_szero = half_dly[HALF_W];
        for (int k = 0; k < 3; k++) begin
            if (e_szero) begin
                e_slot[k] = '0;
            end else if (e_neg[k]) begin
                over = (|quo[k][NUM_W-1:DATA_W]) | (quo[k][DATA_W-1] & |quo[k][DATA_W-2:0]);
                e_slot[k] = over ? {1'b1, {(DATA_W-1){1'b0}}} : -quo[k][DATA_W-1:0];
            end else begin
                over = |quo[k][NUM_W-1:DATA_W-1];
                e_slot[k] = over ? {1'b0, {(DATA_W-1){1'b1}}}
                                 : {1'b0, quo[k][DATA_W-2:0]};
            end
            n_scale[k] = sc_dly[k][SC_RT_W-1] ? {SCALE_W{1'b1}} : sc_dly[k][SCALE_W-1:0];
        end
        case (e_br)
            BR_W: begin
                n_quat[0] = DATA_W'(e_half);
                n_quat[1] = e_slot[0]; n_quat[2] = e_slot[1]; n_quat[3] = e_slot[2];
            end
            BR_X: begin
                n_quat[1] = DATA_W'(e_half);
                n_quat[0] = e_slot[0]; n_quat[2] = e_slot[1]; n_quat[3] = e_slot[2];
            end
            BR_Y: begin
                n_quat[2] = DATA_W'(e_half);
                n_quat[0] = e_slot[0]; n_quat[1] = e_slot[1]; n_quat[3] = e_slot[2];
            end
            default: begin
                n_quat[3] = DATA_W'(e_half);
                n_quat[0] = e_slot[0]; n_quat[1] = e_slot[1]; n_quat[2] = e_slot[2];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_scale_x <= n_scale[0];
            o_scale_y <= n_scale[1];
            o_scale_z <= n_scale[2];
            o_quat_w  <= n_quat[0];
            o_quat_x  <= n_quat[1];
            o_quat_y  <= n_quat[2];
            o_quat_z  <= n_quat[3];
            o_pos_x   <= e_pos[DATA_W-1:0];
            o_pos_y   <= e_pos[2*DATA_W-1:DATA_W];
            o_pos_z   <= e_pos[3*DATA_W-1:2*DATA_W];
        end
    end
endmodule

FILE: test/tb_matrix_to_scale_quat_pos.sv
// Testbench for the transform decomposition block: random and directed matrices, scoreboard check.
module tb_matrix_to_scale_quat_pos;
    timeunit 1ns;
    timeprecision 1ps;
    import mtsq_pkg::*;

    localparam int LATENCY = 76;
    localparam int N_RANDOM = 2000;

    typedef logic signed [31:0] t_q;

    typedef struct packed {
        t_q m00, m01, m02, m10, m11, m12, m20, m21, m22, tx, ty, tz;
    } t_xform;

    typedef struct packed {
        logic [30:0] sx, sy, sz;
        t_q qw, qx, qy, qz, px, py, pz;
    } t_decomp;

    logic i_clk, i_rst_n, i_valid, o_ready, o_valid, i_ready;
    t_q i_xaxis_x, i_xaxis_y, i_xaxis_z, i_yaxis_x, i_yaxis_y, i_yaxis_z;
    t_q i_zaxis_x, i_zaxis_y, i_zaxis_z, i_trans_x, i_trans_y, i_trans_z;
    logic [30:0] o_scale_x, o_scale_y, o_scale_z;
    t_q o_quat_w, o_quat_x, o_quat_y, o_quat_z, o_pos_x, o_pos_y, o_pos_z;

    matrix_to_scale_quat_pos dut (.*);

    t_xform pending_xforms[$];
    t_decomp expected_decomps[$];
    int errors = 0;
    int n_checked = 0;
    int branch_hits[4];
    int send_wait = 0;
    int recv_wait = 0;
    bit hold_off = 0;

    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic logic [30:0] axis_length(longint a, longint b, longint c);
        longint unsigned r;
        r = floor_root(longint'(a * a) + longint'(b * b) + longint'(c * c));
        if (r > 64'h7FFF_FFFF) r = 64'h7FFF_FFFF;
        return r[30:0];
    endfunction

    function automatic longint div_by_s(longint num, longint unsigned s);
        longint unsigned mag, q;
        mag = (num < 0) ? longint'(-num) : num;
        if (s == 0) return 0;
        q = (mag << 16) / s;
        if (q > (64'd1 << 40)) q = 64'd1 << 40;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic t_q clip32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic t_decomp decompose(t_xform t);
        t_decomp d;
        longint m00, m01, m02, m10, m11, m12, m20, m21, m22, tr, arg, half, w, x, y, z;
        longint unsigned r, s;
        t_branch br;
        m00 = t.m00; m01 = t.m01; m02 = t.m02;
        m10 = t.m10; m11 = t.m11; m12 = t.m12;
        m20 = t.m20; m21 = t.m21; m22 = t.m22;
        d.sx = axis_length(m00, m01, m02);
        d.sy = axis_length(m10, m11, m12);
        d.sz = axis_length(m20, m21, m22);
        tr = m00 + m11 + m22;
        if (tr > 0) begin
            br = BR_W; arg = tr + Q_ONE;
        end else if (m00 > m11 && m00 > m22) begin
            br = BR_X; arg = Q_ONE + m00 - m11 - m22;
        end else if (m11 > m22) begin
            br = BR_Y; arg = Q_ONE + m11 - m00 - m22;
        end else begin
            br = BR_Z; arg = Q_ONE + m22 - m00 - m11;
        end
        if (arg < 0) arg = 0;
        r = floor_root(longint'(arg) << 16);
        s = r * 2;
        half = r >> 1;
        case (br)
            BR_W: begin
                w = half; x = div_by_s(m21 - m12, s);
                y = div_by_s(m02 - m20, s); z = div_by_s(m10 - m01, s);
            end
            BR_X: begin
                w = div_by_s(m21 - m12, s); x = half;
                y = div_by_s(m01 + m10, s); z = div_by_s(m02 + m20, s);
            end
            BR_Y: begin
                w = div_by_s(m02 - m20, s); x = div_by_s(m01 + m10, s);
                y = half; z = div_by_s(m12 + m21, s);
            end
            default: begin
                w = div_by_s(m10 - m01, s); x = div_by_s(m02 + m20, s);
                y = div_by_s(m12 + m21, s); z = half;
            end
        endcase
        branch_hits[br]++;
        d.qw = clip32(w); d.qx = clip32(x); d.qy = clip32(y); d.qz = clip32(z);
        d.px = t.tx; d.py = t.ty; d.pz = t.tz;
        return d;
    endfunction

    // mix of full-range words, small values near the unit and extremes
    function automatic t_q rand_entry();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'sh7FFF_FFFF - $urandom_range(0, 3);
            2: return 32'sh8000_0000 + $urandom_range(0, 3);
            3: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
            default: return $signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000;
        endcase
    endfunction

    function automatic t_xform rand_xform();
        t_xform t;
        t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        {t.m00, t.m01, t.m02, t.m10, t.m11, t.m12, t.m20, t.m21, t.m22} =
            {rand_entry(), rand_entry(), rand_entry(), rand_entry(), rand_entry(),
             rand_entry(), rand_entry(), rand_entry(), rand_entry()};
        // steer the diagonal toward the x, y or z quaternion branch
        case ($urandom_range(0, 4))
            1: begin t.m00 = 32'sh0001_0000; t.m11 = -32'sh0001_0000; t.m22 = -32'sh0001_0000; end
            2: begin t.m00 = -32'sh0001_0000; t.m11 = 32'sh0001_0000; t.m22 = -32'sh0001_0000; end
            3: begin t.m00 = -32'sh0001_0000; t.m11 = -32'sh0001_0000; t.m22 = 32'sh0001_0000; end
            default: ;
        endcase
        return t;
    endfunction

    function automatic t_xform diag(t_q a, t_q b, t_q c);
        t_xform t;
        t = '0;
        t.m00 = a; t.m11 = b; t.m22 = c;
        return t;
    endfunction

    initial begin
        i_clk = 0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // driver; the offered item stays at the front of the queue until accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 0;
            send_wait <= 0;
        end else if (i_valid && !o_ready) begin
            // hold the offered item
        end else begin
            if (i_valid) expected_decomps.push_back(decompose(pending_xforms.pop_front()));
            if ((!i_valid || o_ready) && send_wait > 0) begin
                send_wait <= send_wait - 1;
                i_valid <= 0;
            end else if (pending_xforms.size() > 0) begin
                t_xform t;
                t = pending_xforms[0];
                i_valid <= 1;
                {i_xaxis_x, i_xaxis_y, i_xaxis_z, i_yaxis_x, i_yaxis_y, i_yaxis_z,
                 i_zaxis_x, i_zaxis_y, i_zaxis_z, i_trans_x, i_trans_y, i_trans_z} <= t;
                send_wait <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
            end else begin
                i_valid <= 0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 0;
            recv_wait <= 0;
        end else begin
            if (o_valid && i_ready) begin
                t_decomp got, exp_d;
                got = {o_scale_x, o_scale_y, o_scale_z, o_quat_w, o_quat_x, o_quat_y,
                       o_quat_z, o_pos_x, o_pos_y, o_pos_z};
                n_checked++;
                if (expected_decomps.size() == 0) begin
                    $display("%0t: unexpected item %h", $time, got);
                    errors++;
                end else begin
                    exp_d = expected_decomps.pop_front();
                    if (got.sx !== exp_d.sx) $display("%0t scale_x exp %h got %h", $time, exp_d.sx, got.sx);
                    if (got.sy !== exp_d.sy) $display("%0t scale_y exp %h got %h", $time, exp_d.sy, got.sy);
                    if (got.sz !== exp_d.sz) $display("%0t scale_z exp %h got %h", $time, exp_d.sz, got.sz);
                    if (got.qw !== exp_d.qw) $display("%0t quat_w exp %h got %h", $time, exp_d.qw, got.qw);
                    if (got.qx !== exp_d.qx) $display("%0t quat_x exp %h got %h", $time, exp_d.qx, got.qx);
                    if (got.qy !== exp_d.qy) $display("%0t quat_y exp %h got %h", $time, exp_d.qy, got.qy);
                    if (got.qz !== exp_d.qz) $display("%0t quat_z exp %h got %h", $time, exp_d.qz, got.qz);
                    if (got.px !== exp_d.px) $display("%0t pos_x exp %h got %h", $time, exp_d.px, got.px);
                    if (got.py !== exp_d.py) $display("%0t pos_y exp %h got %h", $time, exp_d.py, got.py);
                    if (got.pz !== exp_d.pz) $display("%0t pos_z exp %h got %h", $time, exp_d.pz, got.pz);
                    if (got !== exp_d) errors++;
                end
            end
            if (hold_off) begin
                i_ready <= 0;
            end else if (recv_wait > 0) begin
                recv_wait <= recv_wait - 1;
                i_ready <= 0;
            end else begin
                i_ready <= 1;
                if (o_valid && i_ready)
                    recv_wait <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 18) : 0;
            end
        end
    end

    // one long receiver stall so the pipeline fills and backs up
    initial begin
        wait (n_checked == 300);
        hold_off <= 1;
        repeat (400) @(posedge i_clk);
        hold_off <= 0;
    end

    initial begin
        t_xform t;
        i_rst_n = 0;
        i_valid = 0;
        i_ready = 0;
        {i_xaxis_x, i_xaxis_y, i_xaxis_z, i_yaxis_x, i_yaxis_y, i_yaxis_z,
         i_zaxis_x, i_zaxis_y, i_zaxis_z, i_trans_x, i_trans_y, i_trans_z} = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: identity, each branch, ties, extremes
        pending_xforms.push_back(diag(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000));
        pending_xforms.push_back('0);
        pending_xforms.push_back(diag(32'sh0001_0000, -32'sh0001_0000, -32'sh0001_0000));
        pending_xforms.push_back(diag(-32'sh0001_0000, 32'sh0001_0000, -32'sh0001_0000));
        pending_xforms.push_back(diag(-32'sh0001_0000, -32'sh0001_0000, 32'sh0001_0000));
        pending_xforms.push_back(diag(-32'sh0001_0000, -32'sh0001_0000, -32'sh0001_0000));
        pending_xforms.push_back(diag(32'sh0000_0000, 32'sh0000_0000, -32'sh0000_0001));
        pending_xforms.push_back(diag(-32'sh0000_0001, -32'sh0000_0001, -32'sh0000_0001));
        pending_xforms.push_back({12{32'sh7FFF_FFFF}});
        pending_xforms.push_back({12{32'sh8000_0000}});
        pending_xforms.push_back({12{32'shFFFF_FFFF}});
        t = diag(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
        t.m01 = 32'sh7FFF_FFFF; t.m10 = 32'sh7FFF_FFFF; t.m02 = 32'sh7FFF_FFFF;
        pending_xforms.push_back(t);
        t = diag(32'sh0000_0001, -32'sh0000_0001, 32'sh0000_0000);
        t.m21 = 32'sh7FFF_FFFF; t.m12 = 32'sh8000_0000;
        pending_xforms.push_back(t);
        t = diag(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000);
        t.m02 = 32'sh8000_0000; t.m20 = 32'sh7FFF_FFFF; t.m12 = 32'sh7FFF_FFFF;
        pending_xforms.push_back(t);
        t = diag(32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF);
        t.m10 = 32'sh8000_0000; t.m01 = 32'sh7FFF_FFFF;
        pending_xforms.push_back(t);
        for (int i = 0; i < 5; i++) pending_xforms.push_back(rand_xform());

        for (int i = 0; i < N_RANDOM; i++) begin
            pending_xforms.push_back(rand_xform());
            if (pending_xforms.size() > 50) @(posedge i_clk);
        end

        wait (pending_xforms.size() == 0 && !i_valid);
        wait (expected_decomps.size() == 0);
        repeat (LATENCY + 20) @(posedge i_clk);
        $display("checked %0d items; branches w/x/y/z: %0d %0d %0d %0d",
                 n_checked, branch_hits[0], branch_hits[1], branch_hits[2], branch_hits[3]);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule

FILE: matrix_to_scale_quat_pos.f
rtl/core/mtsq_pkg.sv
rtl/core/mtsq_delay.sv
rtl/core/mtsq_sqrt.sv
rtl/core/mtsq_div.sv
rtl/core/matrix_to_scale_quat_pos.sv
test/tb_matrix_to_scale_quat_pos.sv
